### rtl/kdm_pkg.sv
// kdm_pkg: shared types and constants for the kd median split router.
// Payload structs, command codes, register indexes and control/status bundles.
// No dependencies.
package kdm_pkg;

	localparam int DEFAULT_MAX_POINTS = 1024;
	localparam int DEFAULT_DIMS       = 128;

	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 1;

	localparam logic [10:0] POINT_COUNT_RESET = 11'd1024;
	localparam logic [6:0]  SPLIT_AXIS_RESET  = 7'd0;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPLIT_AXIS  = 1'd1;

	// input command codes
	localparam logic [1:0] CMD_MARK  = 2'd0;
	localparam logic [1:0] CMD_ROUTE = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]         command;
		logic [6:0]         axis;
		logic [9:0]         rank;
		logic [9:0]         point_index;
		logic signed [31:0] coordinate;
	} kdm_in_t;

	typedef struct packed {
		logic               side;
		logic [9:0]         new_index;
		logic signed [31:0] side_min;
		logic signed [31:0] side_max;
		logic               status;
	} kdm_out_t;

	// controller to datapath
	typedef struct packed {
		logic take;        // latch the accepted transaction
		logic exec;        // decode, check, write the point map
		logic map_step;    // point map data ready, read the spread store
		logic spread_step; // spread data ready, fold coordinate and write back
		logic load_out;    // move result into the output register
	} kdm_ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic route_ok;    // latched transaction is a route that passes its checks
	} kdm_stat_t;

endpackage

### rtl/kdm_ctrl.sv
// kdm_ctrl: sequencing state machine of the kd median split router.
// Drives the input stall, the output valid and the datapath commands.
// Depends on kdm_pkg.
module kdm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  kdm_pkg::kdm_stat_t  stat,
	output kdm_pkg::kdm_ctrl_t  ctrl
);
	import kdm_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_EXEC   = 5'b00010,
		S_MAP    = 5'b00100,
		S_SPREAD = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	// decode commands from the current state
	always_comb begin
		ctrl             = '0;
		ctrl.take        = (state_q == S_IDLE) && in_valid;
		ctrl.exec        = (state_q == S_EXEC);
		ctrl.map_step    = (state_q == S_MAP);
		ctrl.spread_step = (state_q == S_SPREAD);
		ctrl.load_out    = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = stat.route_ok ? S_MAP : S_DONE;
			end
			S_MAP: begin
				state_d = S_SPREAD;
			end
			S_SPREAD: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (ctrl.load_out) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// hold state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// a taken transaction always leaves idle
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.take |=> state_q == S_EXEC)
		else $error("accepted transaction did not start execution");

	// a result only finishes into a free or draining output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_out |-> !(out_valid_q && out_stall))
		else $error("result loaded over a stalled output");

	// spread lookup follows a point map read
	a_spread_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SPREAD |-> $past(state_q == S_MAP))
		else $error("spread step without point map read");

endmodule

### rtl/kdm_datapath.sv
// kdm_datapath: item registers, point map memory, spread store and output register.
// Executes commands from kdm_ctrl and reports the route check back.
// Depends on kdm_pkg.
module kdm_datapath #(
	parameter int MAX_POINTS = kdm_pkg::DEFAULT_MAX_POINTS,
	parameter int DIMS       = kdm_pkg::DEFAULT_DIMS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  kdm_pkg::kdm_in_t                    in_data,
	output kdm_pkg::kdm_out_t                   out_data,
	input  logic                                cfg_we,
	input  logic [kdm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [kdm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  kdm_pkg::kdm_ctrl_t                  ctrl,
	output kdm_pkg::kdm_stat_t                  stat
);
	import kdm_pkg::*;

	localparam int AW     = $clog2(MAX_POINTS);
	localparam int NSLOT  = 2 * DIMS;
	localparam int SW     = $clog2(NSLOT);

	// configuration registers
	logic [10:0] point_count_q;
	logic [6:0]  split_axis_q;

	// latched transaction and intermediate results
	kdm_in_t     item_q;
	kdm_out_t    res_q, res_d, out_q;
	logic [10:0] map_rd_q;
	logic        side_q;
	logic [9:0]  idx_q;
	logic [SW-1:0] slot_q;
	logic [63:0] spread_rd_q;
	logic [NSLOT-1:0] seen_q;

	// memories
	logic [10:0] map_mem    [MAX_POINTS];
	logic [63:0] spread_mem [NSLOT];

	// range checks and mark arithmetic
	logic [8:0]  axis_w;
	logic [16:0] pidx_w;
	logic [AW-1:0] map_addr;
	logic        axis_ok, pidx_ok, mark_ok, map_we;
	logic [10:0] split, rank_w;
	logic        mark_side;
	logic [9:0]  mark_idx;
	logic [9:0]  slot_sum;
	logic [SW-1:0] slot_d;
	logic signed [31:0] old_min, old_max, new_min, new_max, coord;
	logic        was_seen;

	assign axis_w   = 9'(item_q.axis);
	assign pidx_w   = 17'(item_q.point_index);
	assign map_addr = pidx_w[AW-1:0];
	assign axis_ok  = axis_w < 9'(DIMS);
	assign pidx_ok  = pidx_w < 17'(MAX_POINTS);
	assign rank_w   = 11'(item_q.rank);
	assign split    = point_count_q - {1'b0, point_count_q[10:1]};
	assign mark_ok  = (item_q.axis == split_axis_q) && axis_ok && pidx_ok
		&& (rank_w < point_count_q);
	assign mark_side = !(rank_w < split);
	assign mark_idx  = mark_side ? 10'(rank_w - split) : item_q.rank;
	assign map_we    = ctrl.exec && (item_q.command == CMD_MARK) && mark_ok;

	assign stat.route_ok = (item_q.command == CMD_ROUTE) && axis_ok && pidx_ok;

	// spread slot is side * DIMS + axis
	assign slot_sum = map_rd_q[10] ? (10'(DIMS) + 10'(item_q.axis)) : 10'(item_q.axis);
	assign slot_d   = slot_sum[SW-1:0];

	// fold coordinate into running min and max
	assign coord    = item_q.coordinate;
	assign old_min  = $signed(spread_rd_q[63:32]);
	assign old_max  = $signed(spread_rd_q[31:0]);
	assign was_seen = seen_q[slot_q];
	assign new_min  = (!was_seen || (coord < old_min)) ? coord : old_min;
	assign new_max  = (!was_seen || (coord > old_max)) ? coord : old_max;

	// build the result
	always_comb begin
		res_d = '0;
		if (ctrl.spread_step) begin
			res_d.side      = side_q;
			res_d.new_index = idx_q;
			res_d.side_min  = new_min;
			res_d.side_max  = new_max;
		end else begin
			case (item_q.command)
				CMD_MARK: begin
					if (mark_ok) begin
						res_d.side      = mark_side;
						res_d.new_index = mark_idx;
					end else begin
						res_d.status = 1'b1;
					end
				end
				CMD_ROUTE: begin
					res_d.status = !stat.route_ok;
				end
				CMD_CLEAR: begin
					res_d.status = 1'b0;
				end
				default: begin
					res_d.status = 1'b1;
				end
			endcase
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= POINT_COUNT_RESET;
			split_axis_q  <= SPLIT_AXIS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POINT_COUNT: point_count_q <= cfg_data;
				REG_SPLIT_AXIS:  split_axis_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// seen flags: clear on the clear command, set on each route fold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (ctrl.exec && (item_q.command == CMD_CLEAR)) begin
			seen_q <= '0;
		end else if (ctrl.spread_step) begin
			seen_q[slot_q] <= 1'b1;
		end
	end

	// point map: write on a good mark, registered read every cycle
	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_addr] <= {mark_side, mark_idx};
		map_rd_q <= map_mem[map_addr];
	end

	// spread store: read at the looked-up slot, write back the folded pair
	always_ff @(posedge clk) begin
		if (ctrl.spread_step) spread_mem[slot_q] <= {new_min, new_max};
		spread_rd_q <= spread_mem[slot_d];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctrl.take) item_q <= in_data;
		if (ctrl.map_step) begin
			side_q <= map_rd_q[10];
			idx_q  <= map_rd_q[9:0];
			slot_q <= slot_d;
		end
		if (ctrl.exec || ctrl.spread_step) res_q <= res_d;
		if (ctrl.load_out) out_q <= res_q;
	end

	assign out_data = out_q;

	a_map_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.map_step |-> $past(ctrl.exec && stat.route_ok))
		else $error("point map step without a checked route");

	a_spread_after_map: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.spread_step |-> $past(ctrl.map_step))
		else $error("spread fold without spread read");

	a_seen_set: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.spread_step |=> seen_q[$past(slot_q)])
		else $error("folded slot not marked seen");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.spread_step |=> (res_q.side_min <= res_q.side_max))
		else $error("side minimum above side maximum");

endmodule

### rtl/kd_median_split_router.sv
// kd_median_split_router: top level, joins controller and datapath.
// Depends on kdm_pkg, kdm_ctrl and kdm_datapath.
//
// Median split router for a presorted kd-array. Mark transactions (command 0)
// assign a point to the left or right half by rank and store its side and index
// within the half; route transactions (command 1) look the point up and fold the
// Q16.16 coordinate into that side's running min/max on the given axis; clear
// (command 2) empties the spread store. Every transaction returns exactly one
// result. One transaction is in flight at a time: mark, clear, rejected and
// unknown transactions go from execute straight to done, while routes pass
// through the chain of two registered memory reads (point map, then spread
// store) followed by the spread write-back. The output register lets the
// next transaction be accepted while a result still waits. Write configuration
// only while no transaction is in flight. No clearing pass is needed after reset.
module kd_median_split_router #(
	parameter int MAX_POINTS = kdm_pkg::DEFAULT_MAX_POINTS,
	parameter int DIMS       = kdm_pkg::DEFAULT_DIMS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  kdm_pkg::kdm_in_t                in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output kdm_pkg::kdm_out_t               out_data,
	input  logic                            cfg_we,
	input  logic [kdm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kdm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import kdm_pkg::*;

	kdm_ctrl_t ctrl;
	kdm_stat_t stat;

	kdm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	kdm_datapath #(
		.MAX_POINTS (MAX_POINTS),
		.DIMS       (DIMS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctrl      (ctrl),
		.stat      (stat)
	);

endmodule
